[hw/rtl/assert_macros.svh]
// assertion helpers for the design file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, muted while reset is held
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, live through reset as well
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/oaie_pkg.sv]
package oaie_pkg;

  // store geometry
  localparam int DEPTH   = 64;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // back-word reduction grouping
  localparam int GRP  = 8;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  // operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_ERASE  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;
  localparam logic [1:0] ERR_RANGE = 2'd3;

  // cell actions
  typedef logic [1:0] act_t;
  localparam act_t ACT_HOLD  = 2'd0;
  localparam act_t ACT_LOAD  = 2'd1;
  localparam act_t ACT_LEFT  = 2'd2;
  localparam act_t ACT_RIGHT = 2'd3;

  typedef struct packed {
    act_t act;
    logic last;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [POS_W-1:0]        position;
    logic signed [WORD_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;
    logic [COUNT_W-1:0]       count;
    logic [1:0]               error_code;
  } out_beat_t;

endpackage

[hw/rtl/oaie_cell.sv]
module oaie_cell (
  input  logic                          clk,
  input  oaie_pkg::cell_ctrl_t          ctrl,
  input  logic [oaie_pkg::WORD_W-1:0]   left_word,
  input  logic [oaie_pkg::WORD_W-1:0]   right_word,
  input  logic [oaie_pkg::WORD_W-1:0]   load_word,
  output logic [oaie_pkg::WORD_W-1:0]   word,
  output logic [oaie_pkg::WORD_W-1:0]   cand
);

  logic [oaie_pkg::WORD_W-1:0] word_r;
  logic [oaie_pkg::WORD_W-1:0] word_nxt;
  logic [oaie_pkg::WORD_W-1:0] cand_r;

  // pick the next word from hold, new value or a neighbor
  always_comb begin
    case (ctrl.act)
      oaie_pkg::ACT_HOLD:  word_nxt = word_r;
      oaie_pkg::ACT_LOAD:  word_nxt = load_word;
      oaie_pkg::ACT_LEFT:  word_nxt = left_word;
      oaie_pkg::ACT_RIGHT: word_nxt = right_word;
      default:             word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // back-word candidate, zero unless this cell is the last occupied one
  always_ff @(posedge clk) begin
    cand_r <= ctrl.last ? word_r : '0;
  end

  assign word = word_r;
  assign cand = cand_r;

endmodule

[hw/rtl/oaie_or_tree.sv]
module oaie_or_tree (
  input  logic                        clk,
  input  logic                        load,
  input  logic [oaie_pkg::WORD_W-1:0] cand [oaie_pkg::DEPTH],
  output logic [oaie_pkg::WORD_W-1:0] back_word
);

  logic [oaie_pkg::WORD_W-1:0] grp_r   [oaie_pkg::NGRP];
  logic [oaie_pkg::WORD_W-1:0] grp_nxt [oaie_pkg::NGRP];

  // first level: or within each group of cells
  always_comb begin
    for (int g = 0; g < oaie_pkg::NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < oaie_pkg::GRP; k++) begin
        if (g * oaie_pkg::GRP + k < oaie_pkg::DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | cand[g * oaie_pkg::GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < oaie_pkg::NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // second level: or across the group registers
  always_comb begin
    back_word = '0;
    for (int g = 0; g < oaie_pkg::NGRP; g++) begin
      back_word = back_word | grp_r[g];
    end
  end

endmodule

[hw/rtl/ordered_array_insert_erase.sv]
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall   | oaie_pkg::in_beat_t  (func, position, value)
// out     | output    | out_valid/out_stall | oaie_pkg::out_beat_t (front, back, count, error)
//
// one item at a time: the accept edge shifts the row of cells, then
// the back word goes through a candidate register and a grouped or tree
// before it lands in the output register; in_stall stays high until then.
// reset (rst_n low, synchronous) empties the store and drops out_valid;
// words in the cells are not cleared. a stalled result holds in the output
// register while the next item is taken; only a second result waits for it.
`include "assert_macros.svh"

module ordered_array_insert_erase (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  oaie_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output oaie_pkg::out_beat_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CAND = 2'd1;
  localparam logic [1:0] S_GRP  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                   state_r;
  logic [1:0]                   state_nxt;
  logic [oaie_pkg::CNT_W-1:0]   used_r;
  logic [oaie_pkg::CNT_W-1:0]   used_nxt;
  logic [1:0]                   err_r;
  logic [1:0]                   err_nxt;
  logic                         out_valid_r;
  oaie_pkg::out_beat_t          out_r;

  logic                         in_accept;
  logic                         out_accept;
  logic                         out_load;
  logic                         ok_append;
  logic                         ok_insert;
  logic                         ok_erase;
  logic [oaie_pkg::CMP_W-1:0]   pos_ext;
  logic [oaie_pkg::CMP_W-1:0]   used_ext;
  logic                         full;
  logic                         empty;
  logic [oaie_pkg::DEPTH-1:0]   last_vec;
  logic [oaie_pkg::WORD_W-1:0]  back_w;

  oaie_pkg::cell_ctrl_t         ctrl [oaie_pkg::DEPTH];
  logic [oaie_pkg::WORD_W-1:0]  word_w [oaie_pkg::DEPTH];
  logic [oaie_pkg::WORD_W-1:0]  cand_w [oaie_pkg::DEPTH];
  logic [oaie_pkg::WORD_W-1:0]  lft_w  [oaie_pkg::DEPTH];
  logic [oaie_pkg::WORD_W-1:0]  rgt_w  [oaie_pkg::DEPTH];

  // handshakes
  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // operation checks against the current count
  assign pos_ext  = oaie_pkg::CMP_W'(in_data.position);
  assign used_ext = oaie_pkg::CMP_W'(used_r);
  assign full     = (used_r == oaie_pkg::CNT_W'(oaie_pkg::DEPTH));
  assign empty    = (used_r == '0);

  always_comb begin
    err_nxt   = oaie_pkg::ERR_OK;
    used_nxt  = used_r;
    ok_append = 1'b0;
    ok_insert = 1'b0;
    ok_erase  = 1'b0;
    case (in_data.func)
      oaie_pkg::OP_APPEND: begin
        if (full) begin
          err_nxt = oaie_pkg::ERR_FULL;
        end else begin
          ok_append = 1'b1;
          used_nxt  = used_r + oaie_pkg::CNT_W'(1);
        end
      end
      oaie_pkg::OP_REMOVE: begin
        if (empty) begin
          err_nxt = oaie_pkg::ERR_EMPTY;
        end else begin
          used_nxt = used_r - oaie_pkg::CNT_W'(1);
        end
      end
      oaie_pkg::OP_INSERT: begin
        if (full) begin
          err_nxt = oaie_pkg::ERR_FULL;
        end else if (pos_ext > used_ext) begin
          err_nxt = oaie_pkg::ERR_RANGE;
        end else begin
          ok_insert = 1'b1;
          used_nxt  = used_r + oaie_pkg::CNT_W'(1);
        end
      end
      oaie_pkg::OP_ERASE: begin
        if (empty) begin
          err_nxt = oaie_pkg::ERR_EMPTY;
        end else if (pos_ext >= used_ext) begin
          err_nxt = oaie_pkg::ERR_RANGE;
        end else begin
          ok_erase = 1'b1;
          used_nxt = used_r - oaie_pkg::CNT_W'(1);
        end
      end
      default: begin
        err_nxt = oaie_pkg::ERR_OK;
      end
    endcase
  end

  // row of cells with per-cell action decode
  genvar i;
  generate
    for (i = 0; i < oaie_pkg::DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign lft_w[i] = '0;
      end else begin : g_mid_l
        assign lft_w[i] = word_w[i-1];
      end
      if (i == oaie_pkg::DEPTH - 1) begin : g_last
        assign rgt_w[i] = '0;
      end else begin : g_mid_r
        assign rgt_w[i] = word_w[i+1];
      end

      assign last_vec[i] = (used_r == oaie_pkg::CNT_W'(i + 1));

      always_comb begin
        ctrl[i].last = last_vec[i];
        ctrl[i].act  = oaie_pkg::ACT_HOLD;
        if (in_accept) begin
          if (ok_append && (oaie_pkg::CMP_W'(i) == used_ext)) begin
            ctrl[i].act = oaie_pkg::ACT_LOAD;
          end else if (ok_insert && (oaie_pkg::CMP_W'(i) == pos_ext)) begin
            ctrl[i].act = oaie_pkg::ACT_LOAD;
          end else if (ok_insert && (oaie_pkg::CMP_W'(i) > pos_ext)) begin
            ctrl[i].act = oaie_pkg::ACT_LEFT;
          end else if (ok_erase && (oaie_pkg::CMP_W'(i) >= pos_ext)) begin
            ctrl[i].act = oaie_pkg::ACT_RIGHT;
          end
        end
      end

      oaie_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[i]),
        .left_word  (lft_w[i]),
        .right_word (rgt_w[i]),
        .load_word  (in_data.value),
        .word       (word_w[i]),
        .cand       (cand_w[i])
      );
    end
  endgenerate

  // back word reduction
  oaie_or_tree u_tree (
    .clk       (clk),
    .load      (state_r == S_GRP),
    .cand      (cand_w),
    .back_word (back_w)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_CAND;
      S_CAND:  state_nxt = S_GRP;
      S_GRP:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        used_r <= used_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // error code of the item in flight
  always_ff @(posedge clk) begin
    if (in_accept) begin
      err_r <= err_nxt;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.front_word <= empty ? '0 : word_w[0];
      out_r.back_word  <= back_w;
      out_r.count      <= oaie_pkg::COUNT_W'(used_r);
      out_r.error_code <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `CHK_ALWAYS(a_used_bound, !rst_n || (used_r <= oaie_pkg::CNT_W'(oaie_pkg::DEPTH)), "count above depth")
  `CHK_PROP(a_last_onehot, $onehot0(last_vec), "more than one cell marked last")
  `CHK_PROP(a_refused_keeps, (in_accept && err_nxt != oaie_pkg::ERR_OK) |=> $stable(used_r), "refused op changed count")
  `CHK_PROP(a_grow_one, (in_accept && (ok_append || ok_insert)) |=> (used_r == $past(used_r) + oaie_pkg::CNT_W'(1)), "count did not grow by one")

endmodule

[tb/array_op_checker.sv]
`timescale 1ns / 1ps

module array_op_checker
  import oaie_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending
);

  // shadow copy of the array and its fill level
  logic signed [WORD_W-1:0] words [DEPTH];
  int                       used;

  // status beats still owed by the block, oldest first
  out_beat_t expected_status [$];
  int        beats_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
    used       = 0;
    beats_seen = 0;
  end

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] result %0d: %s expected %h got %h", $realtime, beats_seen, what,
             want, got);
    fail_count++;
  endtask

  // carry out one array operation and return the status it leaves behind
  task automatic apply_array_op(input in_beat_t op, output out_beat_t status);
    int         pos;
    int         i;
    logic [1:0] err;
    pos = op.position;
    err = ERR_OK;
    case (op.func)
      OP_APPEND: begin
        if (used >= DEPTH) begin
          err = ERR_FULL;
        end else begin
          words[used] = op.value;
          used++;
        end
      end
      OP_REMOVE: begin
        if (used == 0) err = ERR_EMPTY;
        else used--;
      end
      OP_INSERT: begin
        // full is checked ahead of the index
        if (used >= DEPTH) begin
          err = ERR_FULL;
        end else if (pos > used) begin
          err = ERR_RANGE;
        end else begin
          for (i = used; i > pos; i--) words[i] = words[i-1];
          words[pos] = op.value;
          used++;
        end
      end
      default: begin
        // erase: empty is checked ahead of the index
        if (used == 0) begin
          err = ERR_EMPTY;
        end else if (pos >= used) begin
          err = ERR_RANGE;
        end else begin
          for (i = pos; i + 1 < used; i++) words[i] = words[i+1];
          used--;
        end
      end
    endcase
    // an empty array reports zero at both ends
    status.front_word = (used == 0) ? '0 : words[0];
    status.back_word  = (used == 0) ? '0 : words[used-1];
    status.count      = COUNT_W'(used);
    status.error_code = err;
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    out_beat_t want;
    out_beat_t next_status;
    if (!rst_n) begin
      used = 0;
      expected_status.delete();
    end else begin
      // result side: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $display("[%0t] result %0d arrived with nothing expected", $realtime,
                   beats_seen);
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          if (out_data.front_word !== want.front_word)
            report_mismatch("front_word", want.front_word, out_data.front_word);
          if (out_data.back_word !== want.back_word)
            report_mismatch("back_word", want.back_word, out_data.back_word);
          if (out_data.count !== want.count)
            report_mismatch("count", 32'(want.count), 32'(out_data.count));
          if (out_data.error_code !== want.error_code)
            report_mismatch("error_code", 32'(want.error_code), 32'(out_data.error_code));
        end
        beats_seen++;
      end
      // request side: predict the status of each accepted beat
      if (in_valid && !in_stall) begin
        apply_array_op(in_data, next_status);
        expected_status = {expected_status, next_status};
      end
    end
    pending = expected_status.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import oaie_pkg::*;

  localparam int RANDOM_OPS  = 1200;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  int        fail_count;
  int        pending;

  // stimulus-side view of the fill level, used only to aim positions
  int level = 0;
  int burst_left = 0;

  // receiver stall pattern state
  int seg_left = 0;
  int stall_mode = 0;
  int hold_left = 0;

  int cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ordered_array_insert_erase dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  array_op_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // receiver: segments of no stall, light, heavy and alternating blocked/open stretches
  always @(posedge clk) begin
    if (seg_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      seg_left   <= $urandom_range(20, 200);
    end else begin
      seg_left <= seg_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 6);
      default: begin
        if (hold_left > 0) begin
          hold_left <= hold_left - 1;
        end else begin
          out_stall <= ~out_stall;
          hold_left <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // word values leaning on the extremes
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // present one beat, hold it until taken, then maybe open a gap
  task automatic send_op(input logic [1:0] func, input int pos,
                         input logic [WORD_W-1:0] word);
    in_beat_t beat;
    int       gap;
    beat.func     = func;
    beat.position = POS_W'(pos);
    beat.value    = word;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    // track the fill level to steer later positions
    case (func)
      OP_APPEND: if (level < DEPTH) level++;
      OP_REMOVE: if (level > 0) level--;
      OP_INSERT: if (level < DEPTH && pos <= level) level++;
      default:   if (level > 0 && pos < level) level--;
    endcase
    // sender bursts with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end
  endtask

  // edge cases on a short array
  task automatic run_directed();
    send_op(OP_REMOVE, 0, 32'h1234_5678);   // remove on empty
    send_op(OP_ERASE, 0, '0);               // erase on empty
    send_op(OP_INSERT, 1, 32'h1111_1111);   // insert past the end of empty
    send_op(OP_INSERT, 0, 32'h7fff_ffff);   // insert into empty
    send_op(OP_APPEND, 127, 32'h8000_0000); // position ignored on append
    send_op(OP_APPEND, 0, '0);
    send_op(OP_APPEND, 64, '1);
    send_op(OP_INSERT, 4, 32'h5555_5555);   // insert exactly at the end
    send_op(OP_INSERT, 0, 32'haaaa_aaaa);   // insert at the front
    send_op(OP_INSERT, 3, 32'h0f0f_0f0f);   // insert in the middle
    send_op(OP_INSERT, 127, 32'h2222_2222); // position all ones
    send_op(OP_INSERT, 64, 32'h3333_3333);  // position top bit only
    send_op(OP_INSERT, 8, 32'h4444_4444);   // one past the end
    send_op(OP_ERASE, 7, '0);               // erase at the count
    send_op(OP_ERASE, 127, '1);
    send_op(OP_ERASE, 0, '0);               // erase the front
    send_op(OP_ERASE, 5, '0);               // erase the last word
    send_op(OP_ERASE, 2, '0);               // erase in the middle
    send_op(OP_REMOVE, 127, '1);            // position ignored on remove
    send_op(OP_REMOVE, 0, '0);
    send_op(OP_ERASE, 0, '0);
    send_op(OP_REMOVE, 0, '0);              // back to empty
    send_op(OP_REMOVE, 0, '0);
  endtask

  // phases that fill, drain or mix, so full and empty are both reached often
  task automatic run_random();
    int phase;
    int phase_left;
    int pick;
    int pos;
    logic [1:0] func;
    phase      = 0;
    phase_left = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (phase_left == 0) begin
        phase      = $urandom_range(0, 2);
        phase_left = $urandom_range(30, 150);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      case (phase)
        0:       func = (pick < 45) ? OP_APPEND : (pick < 85) ? OP_INSERT :
                        (pick < 93) ? OP_ERASE : OP_REMOVE;
        1:       func = (pick < 10) ? OP_APPEND : (pick < 20) ? OP_INSERT :
                        (pick < 60) ? OP_ERASE : OP_REMOVE;
        default: func = 2'($urandom_range(0, 3));
      endcase
      // positions mostly valid, some on the boundary, some anywhere
      pick = $urandom_range(0, 99);
      if (func == OP_APPEND || func == OP_REMOVE || pick < 8)
        pos = $urandom_range(0, 127);
      else if (pick < 15)
        pos = level + $urandom_range(0, 1);
      else if (func == OP_INSERT)
        pos = $urandom_range(0, level);
      else
        pos = (level > 0) ? $urandom_range(0, level - 1) : 0;
      send_op(func, pos, pick_word());
    end
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    rst_n     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    // drain, then leave room for any stray result
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
